>>> rtl/pwpm_pkg.sv
// ----------------------------------------------------------------------------
// Weighted pose mean package
// Shared widths and sequencer state codes.
// ----------------------------------------------------------------------------
package pwpm_pkg;
   localparam int QSUM_W = 48;
   localparam int OSUM_W = 64;
   localparam int STATE_W = 4;

   localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STATE_W-1:0] ST_MUL   = 4'd1;
   localparam logic [STATE_W-1:0] ST_MAX   = 4'd2;
   localparam logic [STATE_W-1:0] ST_NORM  = 4'd3;
   localparam logic [STATE_W-1:0] ST_SQ    = 4'd4;
   localparam logic [STATE_W-1:0] ST_SQRT  = 4'd5;
   localparam logic [STATE_W-1:0] ST_DIV   = 4'd6;
   localparam logic [STATE_W-1:0] ST_OUT   = 4'd7;
   localparam logic [STATE_W-1:0] ST_SQACC = 4'd8;
endpackage

>>> rtl/particle_weighted_pose_mean.sv
// ----------------------------------------------------------------------------
// Particle weighted pose mean
// Accumulates weighted quaternion and offset sums over a particle set and,
// on the last particle, emits the saturated offsets and the unit quaternion.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake
// req_*    in         start & !busy accepts one item
// rsp_*    out        rsp_valid for one cycle, no backpressure
//
// A particle's seven products go through one 32x16 multiplier, which also
// squares for the last particle's normalization: one-bit shifting, squaring and
// summing, 32 square root steps and 4 divisions of 47 steps each.
// Reset clears all sums at once.
// The receiver cannot stall; busy stays high until the result has been shown.
module particle_weighted_pose_mean (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [15:0] req_weight,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [31:0] req_offset_x,
   input  logic signed [31:0] req_offset_y,
   input  logic signed [31:0] req_offset_z,
   input  logic               req_last_particle,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_mean_w,
   output logic signed [15:0] rsp_mean_x,
   output logic signed [15:0] rsp_mean_y,
   output logic signed [15:0] rsp_mean_z,
   output logic signed [31:0] rsp_mean_offset_x,
   output logic signed [31:0] rsp_mean_offset_y,
   output logic signed [31:0] rsp_mean_offset_z,
   output logic               rsp_zero_norm
);
   import pwpm_pkg::*;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [15:0] w_ff, w_in;
   logic signed [31:0] opnd_ff [7], opnd_in [7];
   logic last_ff, last_in;
   logic [QSUM_W-1:0] qsum_ff [4], qsum_in [4];
   logic [OSUM_W-1:0] osum_ff [3], osum_in [3];
   logic [QSUM_W-1:0] mag_ff [4], mag_in [4];
   logic [3:0] neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;     // N, then sqrt remainder
   logic [31:0] root_ff, root_in;
   logic [63:0] prod_ff, prod_in;
   logic [46:0] num_ff, num_in;     // division dividend/quotient shifter
   logic [32:0] rem_ff, rem_in;
   logic [15:0] quo_ff [4], quo_in [4];
   logic rsp_valid_ff, rsp_valid_in;
   logic zero_ff, zero_in;
   logic [31:0] ores_ff [3], ores_in [3];

   // Shared multiplier operands.
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [QSUM_W-1:0] maxm;
   logic [65:0] sq_trial;
   logic [32:0] div_trial;
   logic [63:0] fsum;

   function automatic logic [31:0] off_out(input logic [63:0] s);
      logic [63:0] f;
      f = {{16{s[63]}}, s[63:16]} + {63'd0, s[15]};
      if (f[63] && f[62:31] != 32'hFFFFFFFF) begin
         off_out = 32'h80000000;
      end else if (!f[63] && f[62:31] != 32'd0) begin
         off_out = 32'h7FFFFFFF;
      end else begin
         off_out = f[31:0];
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      w_in = w_ff;
      opnd_in = opnd_ff;
      last_in = last_ff;
      qsum_in = qsum_ff;
      osum_in = osum_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      root_in = root_ff;
      prod_in = prod_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      rsp_valid_in = 1'b0;
      zero_in = zero_ff;
      ores_in = ores_ff;
      mul_a = '0;
      mul_b = '0;
      maxm = mag_ff[0] | mag_ff[1] | mag_ff[2] | mag_ff[3];
      sq_trial = '0;
      div_trial = '0;
      fsum = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               w_in = req_weight;
               opnd_in[0] = 32'(req_quat_w);
               opnd_in[1] = 32'(req_quat_x);
               opnd_in[2] = 32'(req_quat_y);
               opnd_in[3] = 32'(req_quat_z);
               opnd_in[4] = req_offset_x;
               opnd_in[5] = req_offset_y;
               opnd_in[6] = req_offset_z;
               last_in = req_last_particle;
               idx_in = 3'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_a = {1'b0, 16'd0, w_ff};
            mul_b = 33'(opnd_ff[idx_ff]);
            if (idx_ff < 3'd4) begin
               qsum_in[idx_ff[1:0]] = qsum_ff[idx_ff[1:0]] + mul_p[QSUM_W-1:0];
            end else begin
               osum_in[2'(idx_ff - 3'd4)] = osum_ff[2'(idx_ff - 3'd4)] + mul_p[63:0];
            end
            if (idx_ff == 3'd6) begin
               if (last_ff) begin
                  for (int i = 0; i < 4; i++) begin
                     neg_in[i] = qsum_in[i][QSUM_W-1];
                     mag_in[i] = neg_in[i] ? -qsum_in[i] : qsum_in[i];
                  end
                  for (int i = 0; i < 3; i++) begin
                     ores_in[i] = off_out(osum_in[i]);
                  end
                  state_in = ST_MAX;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_MAX: begin
            // The OR of the magnitudes has the same top bit as their maximum.
            if (maxm == '0) begin
               zero_in = 1'b1;
               for (int i = 0; i < 4; i++) quo_in[i] = '0;
               state_in = ST_OUT;
            end else begin
               zero_in = 1'b0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (maxm[QSUM_W-1:30] != '0) begin
               for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!maxm[29]) begin
               for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               idx_in = 3'd0;
               acc_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            mul_a = {3'd0, mag_ff[idx_ff[1:0]][29:0]};
            mul_b = {3'd0, mag_ff[idx_ff[1:0]][29:0]};
            prod_in = mul_p[63:0];
            state_in = ST_SQACC;
         end
         ST_SQACC: begin
            acc_in = acc_ff + prod_ff;
            if (idx_ff == 3'd3) begin
               root_in = '0;
               prod_in = acc_in;
               acc_in = '0;
               cnt_in = 6'd32;
               state_in = ST_SQRT;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = ST_SQ;
            end
         end
         ST_SQRT: begin
            // Restoring square root, two radicand bits per step.
            sq_trial = {acc_ff[63:0], prod_ff[63:62]} - {32'd0, root_ff, 2'b01};
            prod_in = prod_ff << 2;
            if (!sq_trial[65]) begin
               acc_in = sq_trial[63:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               acc_in = {acc_ff[61:0], prod_ff[63:62]};
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               idx_in = 3'd0;
               num_in = {3'd0, mag_ff[0][29:0], 14'd0} + {16'd0, root_in[31:1]};
               rem_in = '0;
               cnt_in = 6'd47;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_trial = {rem_ff[31:0], num_ff[46]} - {1'b0, root_ff};
            if (!div_trial[32]) begin
               rem_in = div_trial;
               num_in = {num_ff[45:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[46]};
               num_in = {num_ff[45:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               quo_in[idx_ff[1:0]] = neg_ff[idx_ff[1:0]] ? -num_in[15:0] : num_in[15:0];
               if (idx_ff == 3'd3) begin
                  state_in = ST_OUT;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  num_in = {3'd0, mag_ff[2'(idx_ff + 3'd1)][29:0], 14'd0}
                     + {16'd0, root_ff[31:1]};
                  rem_in = '0;
                  cnt_in = 6'd47;
               end
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            for (int i = 0; i < 4; i++) qsum_in[i] = '0;
            for (int i = 0; i < 3; i++) osum_in[i] = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) qsum_ff[i] <= '0;
         for (int i = 0; i < 3; i++) osum_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         qsum_ff <= qsum_in;
         osum_ff <= osum_in;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      w_ff <= w_in;
      opnd_ff <= opnd_in;
      last_ff <= last_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      zero_ff <= zero_in;
      ores_ff <= ores_in;
   end

   assign busy = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean_w = quo_ff[0];
   assign rsp_mean_x = quo_ff[1];
   assign rsp_mean_y = quo_ff[2];
   assign rsp_mean_z = quo_ff[3];
   assign rsp_mean_offset_x = ores_ff[0];
   assign rsp_mean_offset_y = ores_ff[1];
   assign rsp_mean_offset_z = ores_ff[2];
   assign rsp_zero_norm = zero_ff;

   a_resp_after_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_valid) else $error("missing result");
   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("idle while showing result");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> qsum_ff[0] == '0 && osum_ff[0] == '0) else $error("sums not cleared");
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Weighted pose mean testbench
// Drives particle sets with bursts and gaps, predicts each pose result from
// its own model of the sums and normalization or from the directed table, and compares all fields.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        [15:0] weight;
      logic signed [15:0] qw, qx, qy, qz;
      logic signed [31:0] ox, oy, oz;
      logic               last;
   } particle_type;

   typedef struct packed {
      logic signed [15:0] mw, mx, my, mz;
      logic signed [31:0] ox, oy, oz;
      logic               zn;
   } pose_type;

   typedef struct packed {
      particle_type p;
      logic         typed;
      pose_type     res;
   } row_type;

   localparam int WATCHDOG = 3000;
   localparam int N_RANDOM = 550;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   particle_type drv = '0;
   logic signed [15:0] rsp_mean_w, rsp_mean_x, rsp_mean_y, rsp_mean_z;
   logic signed [31:0] rsp_mean_offset_x, rsp_mean_offset_y, rsp_mean_offset_z;
   logic rsp_zero_norm;

   particle_weighted_pose_mean u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_weight(drv.weight), .req_quat_w(drv.qw), .req_quat_x(drv.qx),
      .req_quat_y(drv.qy), .req_quat_z(drv.qz), .req_offset_x(drv.ox),
      .req_offset_y(drv.oy), .req_offset_z(drv.oz),
      .req_last_particle(drv.last), .rsp_valid(rsp_valid),
      .rsp_mean_w(rsp_mean_w), .rsp_mean_x(rsp_mean_x), .rsp_mean_y(rsp_mean_y),
      .rsp_mean_z(rsp_mean_z), .rsp_mean_offset_x(rsp_mean_offset_x),
      .rsp_mean_offset_y(rsp_mean_offset_y), .rsp_mean_offset_z(rsp_mean_offset_z),
      .rsp_zero_norm(rsp_zero_norm)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   logic [47:0] quat_acc[4];
   logic [63:0] offset_acc[3];
   pose_type pending_poses[$];
   logic     cur_typed = 0;
   pose_type cur_pose = '0;
   int       n_errors = 0;
   int       idle_cycles = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Round half up to Q16.16, then clamp to 32 bits.
   function automatic logic signed [31:0] reduce_offset(input logic signed [63:0] s);
      logic signed [63:0] f;
      f = s >>> 16;
      f = f + 64'(s[15]);
      if (f > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (f < -64'sh80000000) return 32'sh80000000;
      return f[31:0];
   endfunction

   function automatic void accumulate_particle(input particle_type p, output logic emit,
                                               output pose_type r);
      logic signed [15:0] q[4];
      logic signed [31:0] o[3];
      logic [63:0] mag[4], maxm, n2, rt, quo;
      logic neg[4];
      longint prod;
      q = '{p.qw, p.qx, p.qy, p.qz};
      o = '{p.ox, p.oy, p.oz};
      for (int i = 0; i < 4; i++) begin
         prod = longint'(p.weight) * longint'(q[i]);
         quat_acc[i] = quat_acc[i] + prod[47:0];
      end
      for (int i = 0; i < 3; i++) begin
         prod = longint'(p.weight) * longint'(o[i]);
         offset_acc[i] = offset_acc[i] + prod;
      end
      emit = p.last;
      r = '0;
      if (!p.last) return;
      maxm = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = quat_acc[i][47];
         mag[i] = {16'd0, neg[i] ? -quat_acc[i] : quat_acc[i]};
         if (mag[i] > maxm) maxm = mag[i];
      end
      if (maxm == 0) begin
         r.zn = 1;
      end else begin
         while (maxm >= (64'd1 << 30)) begin
            maxm = maxm >> 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
         end
         while (maxm < (64'd1 << 29)) begin
            maxm = maxm << 1;
            for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
         end
         n2 = 0;
         for (int i = 0; i < 4; i++) n2 = n2 + mag[i] * mag[i];
         rt = int_sqrt(n2);
         for (int i = 0; i < 4; i++) begin
            quo = ((mag[i] << 14) + (rt >> 1)) / rt;
            q[i] = neg[i] ? -quo[15:0] : quo[15:0];
         end
         r.mw = q[0]; r.mx = q[1]; r.my = q[2]; r.mz = q[3];
      end
      r.ox = reduce_offset(offset_acc[0]);
      r.oy = reduce_offset(offset_acc[1]);
      r.oz = reduce_offset(offset_acc[2]);
      for (int i = 0; i < 4; i++) quat_acc[i] = 0;
      for (int i = 0; i < 3; i++) offset_acc[i] = 0;
   endfunction

   always @(posedge clock) begin
      pose_type want, got, pred;
      logic emit;
      if (!reset) begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            got = '{rsp_mean_w, rsp_mean_x, rsp_mean_y, rsp_mean_z, rsp_mean_offset_x,
                    rsp_mean_offset_y, rsp_mean_offset_z, rsp_zero_norm};
            if (pending_poses.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("unexpected result %h", got);
            end else begin
               want = pending_poses.pop_front();
               if (got !== want) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display({"mismatch: w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d",
                               " ox %h/%h oy %h/%h oz %h/%h zn %b/%b"},
                        want.mw, got.mw, want.mx, got.mx, want.my, got.my, want.mz, got.mz,
                        want.ox, got.ox, want.oy, got.oy, want.oz, got.oz, want.zn, got.zn);
               end
            end
         end
         if (start && !busy) begin
            accumulate_particle(drv, emit, pred);
            if (emit) pending_poses.push_back(cur_typed ? cur_pose : pred);
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic send_particle(input particle_type p, input logic typed,
                                input pose_type res);
      @(negedge clock);
      drv <= p;
      cur_typed <= typed;
      cur_pose <= res;
      start <= 1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      start <= 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic particle_type mk(input logic [15:0] w, input logic [15:0] qw, qx, qy, qz,
                                       input logic [31:0] ox, oy, oz, input logic last);
      return '{w, qw, qx, qy, qz, ox, oy, oz, last};
   endfunction

   function automatic particle_type random_particle(input logic last);
      particle_type p;
      p.weight = $urandom;
      case ($urandom_range(0, 5))
         0: p.weight = 16'hFFFF;
         1: p.weight = $urandom_range(0, 3);
         default: ;
      endcase
      p.qw = $urandom; p.qx = $urandom; p.qy = $urandom; p.qz = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         p.qw = $signed(p.qw) >>> 8; p.qx = $signed(p.qx) >>> 8;
         p.qy = $signed(p.qy) >>> 8; p.qz = $signed(p.qz) >>> 8;
      end
      p.ox = $urandom; p.oy = $urandom; p.oz = $urandom;
      p.last = last;
      return p;
   endfunction

   row_type stim[$];
   pose_type zero_pose, sat_hi, sat_lo, half_round;

   initial begin
      int sent, burst, set_len;
      for (int i = 0; i < 4; i++) quat_acc[i] = 0;
      for (int i = 0; i < 3; i++) offset_acc[i] = 0;
      zero_pose = '0; zero_pose.zn = 1;
      sat_hi = zero_pose; sat_hi.ox = 32'sh7FFFFFFF; sat_hi.oy = 32'sh7FFFFFFF;
      sat_hi.oz = 32'sh7FFFFFFF;
      sat_lo = zero_pose; sat_lo.ox = 32'sh80000000; sat_lo.oy = 32'sh80000000;
      sat_lo.oz = 32'sh80000000;
      half_round = zero_pose; half_round.ox = 1;

      // Zero weight leaves the sums at zero, so the flag is raised.
      stim.push_back('{mk(0, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 32'h7FFFFFFF,
                          32'h80000000, 5, 1), 1, zero_pose});
      stim.push_back('{mk(16'hFFFF, 16384, 0, 0, 0, 0, 0, 0, 1), 0, '0});
      stim.push_back('{mk(16'hFFFF, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 0), 0, '0});
      stim.push_back('{mk(16'hFFFF, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 1), 1, sat_hi});
      stim.push_back('{mk(16'hFFFF, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                          32'h80000000, 0), 0, '0});
      stim.push_back('{mk(16'hFFFF, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                          32'h80000000, 1), 1, sat_lo});
      // Exact halves: plus one half rounds up, minus one half rounds to zero.
      stim.push_back('{mk(1, 0, 0, 0, 0, 32'h8000, 32'hFFFF8000, 0, 1), 1, half_round});
      stim.push_back('{mk(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h12345678,
                          32'h80000000, 32'h7FFFFFFF, 1), 0, '0});
      stim.push_back('{mk(1, 0, 0, 0, 1, 1, 0, 32'hFFFFFFFF, 1), 0, '0});
      stim.push_back('{mk(300, 16'hF000, 16'h0100, 16'hFF00, 16'h0010, 1000, 2000, 3000, 0),
                       0, '0});
      stim.push_back('{mk(40000, 16'hC000, 16'h2000, 16'hE000, 16'h1000, 32'hFFFF0000,
                          32'h00010000, 7, 0), 0, '0});
      stim.push_back('{mk(9, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 32'h40000000,
                          32'hC0000000, 0, 1), 0, '0});
      // Opposite particles cancel to a zero quaternion sum.
      stim.push_back('{mk(500, 16'h2000, 16'h1000, 16'hF000, 16'h0800, 100, 200, 300, 0),
                       0, '0});
      stim.push_back('{mk(500, 16'hE000, 16'hF000, 16'h1000, 16'hF800, 100, 200, 300, 1),
                       0, '0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (stim[i]) begin
         send_particle(stim[i].p, stim[i].typed, stim[i].res);
         if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 12));
      end

      // Let the pipeline drain completely once before the random sets.
      pause(1);
      while (pending_poses.size() != 0) @(negedge clock);

      sent = 0;
      burst = $urandom_range(1, 20);
      while (sent < N_RANDOM) begin
         case ($urandom_range(0, 9))
            0: set_len = $urandom_range(30, 70);
            1, 2: set_len = 1;
            default: set_len = $urandom_range(2, 8);
         endcase
         for (int k = 0; k < set_len; k++) begin
            send_particle(random_particle(k == set_len - 1 ||
                          $urandom_range(0, 30) == 0), 0, '0);
            sent++;
            burst--;
            if (burst == 0) begin
               if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
               burst = $urandom_range(1, 20);
            end
         end
      end
      pause(1);

      while (pending_poses.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (n_errors == 0 && pending_poses.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/pwpm_pkg.sv
rtl/particle_weighted_pose_mean.sv
tb/sv/tb.sv
